FILE: hw/rtl/sbcd_pkg.sv
`timescale 1ns / 1ps

package sbcd_pkg;

	// Frame geometry.
	localparam int FrameLen   = 25;
	localparam int StoreBytes = FrameLen - 1;
	localparam int PosW       = 5;
	localparam logic [PosW-1:0] LastPos = PosW'(FrameLen - 1);

	// Channel geometry.
	localparam int NumChan = 8;
	localparam int RawW    = 11;
	localparam int ChanW   = 10;

	// Watchdog.
	localparam int WdW = 10;
	localparam logic [WdW-1:0] WdMax = '1;

	// Configuration port and reset values.
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 11;
	localparam int HdrW     = 8;
	localparam logic [WdW-1:0]  TimeoutReset = WdW'(500);
	localparam logic [HdrW-1:0] HeaderReset  = 8'h0F;
	localparam logic [RawW-1:0] CenterReset  = RawW'(1000);

	typedef enum logic [CfgIdxW-1:0] {
		REG_TIMEOUT = 2'd0,
		REG_HEADER  = 2'd1,
		REG_CENTER  = 2'd2
	} cfg_reg_t;

	// Input kinds carried in tuser.
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// Result causes carried in tuser.
	localparam logic CAUSE_FRAME   = 1'b0;
	localparam logic CAUSE_TIMEOUT = 1'b1;

	// Subtract the center and divide by four, rounding toward zero.
	function automatic logic [ChanW-1:0] scale_chan(input logic [RawW-1:0] raw,
			input logic [RawW-1:0] ctr);
		logic signed [RawW+1:0] diff;
		logic signed [RawW+1:0] biased;
		diff   = signed'({2'b00, raw}) - signed'({2'b00, ctr});
		biased = diff[RawW+1] ? diff + (RawW+2)'(3) : diff;
		return biased[ChanW+1:2];
	endfunction

endpackage

FILE: hw/rtl/sbus_channel_decoder.sv
`timescale 1ns / 1ps

// Serial frame decoder with a receive watchdog. Each input beat is either a
// received byte (tuser 0) or a time tick in milliseconds (tuser 1). Bytes
// fill a 25-byte frame at a wrapping position; on the last byte a frame with
// the configured header and zero bytes 23 and 24 yields one output beat of
// eight decoded channels (tuser 0). Once the watchdog has reached the
// configured timeout, every tick yields one beat of zeroed channels
// (tuser 1). One input beat is taken every cycle: a beat passes an input
// register and one decode stage into the output register. Input ready drops
// only when the input register holds a beat with a result and the output
// register is full and not taken in that cycle. Configuration is to be
// written by the user only while the block is idle; the block itself does
// not enforce this.
module sbus_channel_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [15:8] tick_ms
	input  logic        s_axis_tuser,   // [0] mode
	// Output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // chan0 [9:0] up to chan7 [79:70]
	output logic        m_axis_tuser,   // [0] cause
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [sbcd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [sbcd_pkg::CfgDataW-1:0] cfg_data
);

	// Configuration registers.
	logic [sbcd_pkg::WdW-1:0]  timeout_q;
	logic [sbcd_pkg::HdrW-1:0] header_q;
	logic [sbcd_pkg::RawW-1:0] center_q;

	// Input stage.
	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] byte_s1;
	logic [7:0] tick_s1;

	// Block state.
	logic [7:0]                frame_q [sbcd_pkg::StoreBytes];
	logic [sbcd_pkg::PosW-1:0] pos_q;
	logic [sbcd_pkg::WdW-1:0]  wd_q;

	// Output stage.
	logic                       valid_s2;
	logic [sbcd_pkg::ChanW-1:0] chan_s2 [sbcd_pkg::NumChan];
	logic                       cause_s2;

	logic                                 is_last;
	logic                                 frame_ok;
	logic                                 wd_expired;
	logic                                 has_result;
	logic                                 out_free;
	logic                                 step_s1;
	logic [sbcd_pkg::WdW:0]               wd_sum;
	logic [sbcd_pkg::NumChan*sbcd_pkg::RawW-1:0] packed_bits;
	logic [sbcd_pkg::ChanW-1:0]           chan_calc [sbcd_pkg::NumChan];

	// Configuration writes; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= sbcd_pkg::TimeoutReset;
			header_q  <= sbcd_pkg::HeaderReset;
			center_q  <= sbcd_pkg::CenterReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sbcd_pkg::REG_TIMEOUT: timeout_q <= cfg_data[sbcd_pkg::WdW-1:0];
				sbcd_pkg::REG_HEADER:  header_q  <= cfg_data[sbcd_pkg::HdrW-1:0];
				sbcd_pkg::REG_CENTER:  center_q  <= cfg_data[sbcd_pkg::RawW-1:0];
				default: ;
			endcase
		end
	end

	// Frame check and watchdog state for the beat in the input stage.
	assign is_last    = pos_q >= sbcd_pkg::LastPos;
	assign frame_ok   = (mode_s1 == sbcd_pkg::MODE_BYTE) && is_last
		&& (frame_q[0] == header_q) && (frame_q[sbcd_pkg::StoreBytes-1] == 8'd0)
		&& (byte_s1 == 8'd0);
	assign wd_expired = !(wd_q < timeout_q);
	assign has_result = frame_ok || ((mode_s1 == sbcd_pkg::MODE_TICK) && wd_expired);
	assign wd_sum     = {1'b0, wd_q} + {{(sbcd_pkg::WdW-7){1'b0}}, tick_s1};

	// Handshake: a beat without a result always moves on.
	assign out_free      = !valid_s2 || m_axis_tready;
	assign step_s1       = valid_s1 && (!has_result || out_free);
	assign s_axis_tready = !valid_s1 || step_s1;

	// Channel unpacking from frame bytes 1 to 11, little-endian.
	always_comb begin
		for (int b = 0; b < sbcd_pkg::NumChan * sbcd_pkg::RawW / 8; b++) begin
			packed_bits[b*8 +: 8] = frame_q[b+1];
		end
		for (int c = 0; c < sbcd_pkg::NumChan; c++) begin
			chan_calc[c] = sbcd_pkg::scale_chan(packed_bits[c*sbcd_pkg::RawW +: sbcd_pkg::RawW],
				center_q);
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata[7:0];
			tick_s1 <= s_axis_tdata[15:8];
		end
	end

	// Byte position and watchdog.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			wd_q  <= '0;
		end else if (step_s1) begin
			if (mode_s1 == sbcd_pkg::MODE_BYTE) begin
				if (is_last) begin
					pos_q <= '0;
					if (frame_ok) begin
						wd_q <= '0;
					end
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end else if (!wd_expired) begin
				wd_q <= wd_sum[sbcd_pkg::WdW] ? sbcd_pkg::WdMax : wd_sum[sbcd_pkg::WdW-1:0];
			end
		end
	end

	// Frame store; written at the current position, never cleared.
	always_ff @(posedge clk) begin
		if (step_s1 && (mode_s1 == sbcd_pkg::MODE_BYTE) && !is_last) begin
			frame_q[pos_q] <= byte_s1;
		end
	end

	// Output stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= step_s1 && has_result;
		end
	end

	// Output stage payload: decoded channels or zeros on timeout.
	always_ff @(posedge clk) begin
		if (step_s1 && has_result) begin
			cause_s2 <= frame_ok ? sbcd_pkg::CAUSE_FRAME : sbcd_pkg::CAUSE_TIMEOUT;
			for (int c = 0; c < sbcd_pkg::NumChan; c++) begin
				chan_s2[c] <= frame_ok ? chan_calc[c] : '0;
			end
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = cause_s2;

	always_comb begin
		for (int c = 0; c < sbcd_pkg::NumChan; c++) begin
			m_axis_tdata[c*sbcd_pkg::ChanW +: sbcd_pkg::ChanW] = chan_s2[c];
		end
	end

endmodule
